@@ design/calclk_pkg.sv @@
// ----------------------------------------------------------------------------
// calclk_pkg
// Shared types, constants and helpers for the calendar clock core.
// ----------------------------------------------------------------------------
package calclk_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // every cell carries the widest field
    localparam int CELL_W   = YEAR_W;
    localparam int NCELLS   = 6;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 5;
    localparam int OUT_DATA_W = 48;

    localparam logic [YEAR_W-1:0] YEAR_LIMIT = YEAR_W'(9999);
    localparam logic [YEAR_W-1:0] YEAR_RST   = YEAR_W'(2000);

    // divisibility by 25: y * inv(25) mod 2^14 lands in [0, DIV25_MAX] iff 25 | y
    localparam logic [YEAR_W-1:0] INV25     = YEAR_W'(7209);
    localparam logic [YEAR_W-1:0] DIV25_MAX = YEAR_W'(((1 << YEAR_W) - 1) / 25);

    typedef enum logic [1:0] {
        FN_TICK = 2'd0,
        FN_INC  = 2'd1,
        FN_DEC  = 2'd2,
        FN_LOAD = 2'd3
    } func_t;

    // field selector codes, also the cell index in the chain
    localparam logic [2:0] FS_YEAR   = 3'd0;
    localparam logic [2:0] FS_MONTH  = 3'd1;
    localparam logic [2:0] FS_DAY    = 3'd2;
    localparam logic [2:0] FS_HOUR   = 3'd3;
    localparam logic [2:0] FS_MINUTE = 3'd4;
    localparam logic [2:0] FS_SECOND = 3'd5;

    typedef enum logic [2:0] {
        OP_HOLD = 3'd0,
        OP_TICK = 3'd1,
        OP_INC  = 3'd2,
        OP_DEC  = 3'd3,
        OP_LOAD = 3'd4,
        OP_FIX  = 3'd5
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [CELL_W-1:0]   lo;
        logic [CELL_W-1:0]   hi;
        logic [CELL_W-1:0]   ld;
        logic [CELL_W-1:0]   rv;
    } cell_ctrl_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        begin
            unique case (m)
                4'd2:                      len = leap ? DAY_W'(29) : DAY_W'(28);
                4'd4, 4'd6, 4'd9, 4'd11:   len = DAY_W'(30);
                default:                   len = DAY_W'(31);
            endcase
            return len;
        end
    endfunction

endpackage

@@ design/calclk_leap.sv @@
// ----------------------------------------------------------------------------
// calclk_leap
// Gregorian leap-year test on a binary year, one multiply for the 25 check.
// ----------------------------------------------------------------------------
module calclk_leap (
    input  logic [calclk_pkg::YEAR_W-1:0] year,
    output logic                          leap
);
    import calclk_pkg::*;

    logic [YEAR_W-1:0] prod;
    logic              div25;

    assign prod  = YEAR_W'(year * INV25);
    assign div25 = (prod <= DIV25_MAX);
    // 4 | y and not (100 | y unless 400 | y)
    assign leap  = (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));

endmodule

@@ design/calclk_cell.sv @@
// ----------------------------------------------------------------------------
// calclk_cell
// One counter cell of the calendar chain: holds a field, ticks on carry-in,
// steps up or down, loads or re-fits into range, all with wrap between lo and hi.
// ----------------------------------------------------------------------------
module calclk_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  calclk_pkg::cell_ctrl_t        ctrl,
    input  logic                          carry_in,
    output logic [calclk_pkg::CELL_W-1:0] val,
    output logic [calclk_pkg::CELL_W-1:0] val_next,
    output logic                          carry_out
);
    import calclk_pkg::*;

    logic [CELL_W-1:0] val_reg;
    logic [CELL_W-1:0] src;
    logic              at_top;

    assign at_top = (val_reg >= ctrl.hi);
    assign src    = (ctrl.op == OP_LOAD) ? ctrl.ld : val_reg;

    always_comb begin
        carry_out = 1'b0;
        unique case (ctrl.op)
            OP_TICK: begin
                if (carry_in) begin
                    val_next  = at_top ? ctrl.lo : val_reg + CELL_W'(1);
                    carry_out = at_top;
                end else begin
                    val_next = val_reg;
                end
            end
            OP_INC:  val_next = at_top ? ctrl.lo : val_reg + CELL_W'(1);
            OP_DEC:  val_next = (val_reg <= ctrl.lo) ? ctrl.hi : val_reg - CELL_W'(1);
            OP_LOAD, OP_FIX: begin
                if (src > ctrl.hi) begin
                    val_next = ctrl.lo;
                end else if (src < ctrl.lo) begin
                    val_next = ctrl.hi;
                end else begin
                    val_next = src;
                end
            end
            default: val_next = val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= ctrl.rv;
        end else if (en) begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule

@@ design/calclk_oreg.sv @@
// ----------------------------------------------------------------------------
// calclk_oreg
// Result register with one skid entry, so a beat can be taken while the
// previous result is still stalled on the master side.
// ----------------------------------------------------------------------------
module calclk_oreg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [calclk_pkg::OUT_DATA_W-1:0] in_data,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [calclk_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import calclk_pkg::*;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  skid_valid_reg;
    logic [OUT_DATA_W-1:0] skid_data_reg;
    logic                  pop;
    logic                  push;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = !out_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        if (!pop && push) begin
            skid_data_reg <= in_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ design/calendar_clock_with_adjust_core.sv @@
// An accepted beat's result goes to the output register, or to the skid entry on a stall.
// One command per cycle while s_axis_tready is high; the six-cell chain is combinational.
// A two-entry result buffer keeps s_axis_tready high through a single stalled beat.
// Reset (aresetn low, synchronous): 2000-01-01 00:00:00, leap flag set, no result pending.
// ----------------------------------------------------------------------------
// calendar_clock_with_adjust_core
// Gregorian date/time keeper: tick, per-field adjust and full load commands.
// ----------------------------------------------------------------------------
module calendar_clock_with_adjust_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [13:0] load_year, [17:14] load_month, [22:18] load_day, [27:23] load_hour,
    // [33:28] load_minute, [39:34] load_second
    input  logic [calclk_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] func, [4:2] field_select
    input  logic [calclk_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [13:0] year_now, [17:14] month_now, [22:18] day_now, [27:23] hour_now,
    // [33:28] minute_now, [39:34] second_now, [40] leap_flag, [47:41] zero
    output logic [calclk_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import calclk_pkg::*;

    logic                acc;
    func_t               func;
    logic [2:0]          sel;
    logic [YEAR_W-1:0]   ld_year;
    logic [MONTH_W-1:0]  ld_month;
    logic                is_tick;
    logic                is_load;
    logic                is_adj;
    logic                is_inc;

    cell_ctrl_t          ctrl [NCELLS];
    logic [CELL_W-1:0]   cur  [NCELLS];
    logic [CELL_W-1:0]   nxt  [NCELLS];
    logic [NCELLS-1:0]   cin;
    logic [NCELLS-1:0]   cout;

    logic                leap_reg;
    logic                leap_next;
    logic [YEAR_W-1:0]   year_cur;
    logic [MONTH_W-1:0]  month_cur;
    logic [YEAR_W-1:0]   year_cand;
    logic                cand_leap;
    logic                year_chg;
    logic [MONTH_W-1:0]  month_f;
    logic                leap_f;
    logic [DAY_W-1:0]    mlen_f;
    logic [OUT_DATA_W-1:0] res;

    assign acc      = s_axis_tvalid && s_axis_tready;
    assign func     = func_t'(s_axis_tuser[1:0]);
    assign sel      = s_axis_tuser[4:2];
    assign ld_year  = s_axis_tdata[13:0];
    assign ld_month = s_axis_tdata[17:14];

    assign is_tick  = (func == FN_TICK);
    assign is_load  = (func == FN_LOAD);
    assign is_adj   = (func == FN_INC || func == FN_DEC) && (sel <= FS_SECOND);
    assign is_inc   = (func == FN_INC);

    assign year_cur  = cur[FS_YEAR];
    assign month_cur = cur[FS_MONTH][MONTH_W-1:0];

    // candidate year for any command that can move the year
    always_comb begin
        if (is_load) begin
            year_cand = (ld_year > YEAR_LIMIT) ? '0 : ld_year;
        end else if (func == FN_DEC) begin
            year_cand = (year_cur == '0) ? YEAR_LIMIT : year_cur - YEAR_W'(1);
        end else begin
            year_cand = (year_cur >= YEAR_LIMIT) ? '0 : year_cur + YEAR_W'(1);
        end
    end

    calclk_leap u_leap (
        .year (year_cand),
        .leap (cand_leap)
    );

    // month length seen by the day cell: final month and year of the command
    always_comb begin
        if (is_load) begin
            if (ld_month > MONTH_W'(12)) begin
                month_f = MONTH_W'(1);
            end else if (ld_month == '0) begin
                month_f = MONTH_W'(12);
            end else begin
                month_f = ld_month;
            end
        end else if (is_adj && sel == FS_MONTH) begin
            if (is_inc) begin
                month_f = (month_cur >= MONTH_W'(12)) ? MONTH_W'(1) : month_cur + MONTH_W'(1);
            end else begin
                month_f = (month_cur <= MONTH_W'(1)) ? MONTH_W'(12) : month_cur - MONTH_W'(1);
            end
        end else begin
            month_f = month_cur;
        end
        leap_f = (is_load || (is_adj && sel == FS_YEAR)) ? cand_leap : leap_reg;
        mlen_f = month_len(month_f, leap_f);
    end

    always_comb begin
        for (int j = 0; j < NCELLS; j++) begin
            if (is_tick) begin
                ctrl[j].op = OP_TICK;
            end else if (is_load) begin
                ctrl[j].op = OP_LOAD;
            end else if (is_adj && sel == 3'(j)) begin
                ctrl[j].op = is_inc ? OP_INC : OP_DEC;
            end else if (is_adj && 3'(j) == FS_DAY && (sel == FS_MONTH || sel == FS_YEAR)) begin
                ctrl[j].op = OP_FIX;
            end else begin
                ctrl[j].op = OP_HOLD;
            end
        end
        ctrl[FS_YEAR].lo   = '0;
        ctrl[FS_YEAR].hi   = YEAR_LIMIT;
        ctrl[FS_YEAR].ld   = ld_year;
        ctrl[FS_YEAR].rv   = YEAR_RST;
        ctrl[FS_MONTH].lo  = CELL_W'(1);
        ctrl[FS_MONTH].hi  = CELL_W'(12);
        ctrl[FS_MONTH].ld  = CELL_W'(ld_month);
        ctrl[FS_MONTH].rv  = CELL_W'(1);
        ctrl[FS_DAY].lo    = CELL_W'(1);
        ctrl[FS_DAY].hi    = CELL_W'(mlen_f);
        ctrl[FS_DAY].ld    = CELL_W'(s_axis_tdata[22:18]);
        ctrl[FS_DAY].rv    = CELL_W'(1);
        ctrl[FS_HOUR].lo   = '0;
        ctrl[FS_HOUR].hi   = CELL_W'(23);
        ctrl[FS_HOUR].ld   = CELL_W'(s_axis_tdata[27:23]);
        ctrl[FS_HOUR].rv   = '0;
        ctrl[FS_MINUTE].lo = '0;
        ctrl[FS_MINUTE].hi = CELL_W'(59);
        ctrl[FS_MINUTE].ld = CELL_W'(s_axis_tdata[33:28]);
        ctrl[FS_MINUTE].rv = '0;
        ctrl[FS_SECOND].lo = '0;
        ctrl[FS_SECOND].hi = CELL_W'(59);
        ctrl[FS_SECOND].ld = CELL_W'(s_axis_tdata[39:34]);
        ctrl[FS_SECOND].rv = '0;
    end

    // carry ripples from the seconds cell up to the year cell
    assign cin[NCELLS-1] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < NCELLS; g++) begin : g_cell
            if (g < NCELLS - 1) begin : g_link
                assign cin[g] = cout[g+1];
            end
            calclk_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (acc),
                .ctrl      (ctrl[g]),
                .carry_in  (cin[g]),
                .val       (cur[g]),
                .val_next  (nxt[g]),
                .carry_out (cout[g])
            );
        end
    endgenerate

    assign year_chg  = is_load || (is_adj && sel == FS_YEAR) || (is_tick && cin[FS_YEAR]);
    assign leap_next = year_chg ? cand_leap : leap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leap_reg <= 1'b1;
        end else if (acc) begin
            leap_reg <= leap_next;
        end
    end

    assign res = {7'd0,
                  leap_next,
                  nxt[FS_SECOND][SECOND_W-1:0],
                  nxt[FS_MINUTE][MINUTE_W-1:0],
                  nxt[FS_HOUR][HOUR_W-1:0],
                  nxt[FS_DAY][DAY_W-1:0],
                  nxt[FS_MONTH][MONTH_W-1:0],
                  nxt[FS_YEAR]};

    calclk_oreg u_oreg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_data       (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (month_cur >= MONTH_W'(1)) && (month_cur <= MONTH_W'(12)))
        else $error("month register out of range");

    a_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur[FS_DAY] >= CELL_W'(1)) &&
        (cur[FS_DAY] <= CELL_W'(month_len(month_cur, leap_reg))))
        else $error("day register past month end");

    a_tick_step: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && is_tick && (cur[FS_SECOND] != CELL_W'(59)) |=>
        cur[FS_SECOND] == $past(cur[FS_SECOND]) + CELL_W'(1))
        else $error("tick did not advance seconds");

endmodule
